// ----- hdl/pcf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcf_pkg - shared types and constants of the printf conversion formatter
// Format codes, ASCII constants, sequencer states and the digit character map.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int DIGIT_SLOTS = 22;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 8;
	localparam int FUNC_W      = 4;
	localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);

	localparam logic [FUNC_W-1:0] FN_LITERAL = 4'd0;
	localparam logic [FUNC_W-1:0] FN_CHAR    = 4'd1;
	localparam logic [FUNC_W-1:0] FN_SDEC    = 4'd2;
	localparam logic [FUNC_W-1:0] FN_UDEC    = 4'd3;
	localparam logic [FUNC_W-1:0] FN_HEXL    = 4'd4;
	localparam logic [FUNC_W-1:0] FN_HEXU    = 4'd5;
	localparam logic [FUNC_W-1:0] FN_OCT     = 4'd6;
	localparam logic [FUNC_W-1:0] FN_PTR     = 4'd7;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_HEX,
		RADIX_OCT
	} radix_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PRE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic   load;
		logic   bit_step;
		logic   dig_shift;
		radix_t radix;
	} chain_ctrl_t;

	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_push_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
		input logic upper);
		logic [CHAR_W-1:0] dw;
		dw = {4'h0, d};
		if (d < 4'd10) begin
			return CH_ZERO + dw;
		end else if (upper) begin
			return CH_UA + dw - 8'd10;
		end else begin
			return CH_LA + dw - 8'd10;
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/pcf_elem_if.sv -----
// ----------------------------------------------------------------------------
// pcf_elem_if - format element channel
// One pre-decoded format element per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcf_elem_if import pcf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [FUNC_W-1:0]      func;
	logic                   wide;
	logic [63:0]            operand;

	modport source (output valid, output func, output wide, output operand, input ready);
	modport sink   (input valid, input func, input wide, input operand, output ready);
endinterface

`default_nettype wire

// ----- hdl/pcf_text_if.sv -----
// ----------------------------------------------------------------------------
// pcf_text_if - character output channel
// One ASCII character per transfer, last marks the end of an element.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcf_text_if import pcf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ch;
	logic              last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/pcf_digit_chain.sv -----
// ----------------------------------------------------------------------------
// pcf_digit_chain - bit-serial radix conversion chain
// Shifts the magnitude in one bit per cycle through a row of digit slots
// (add-3 correction for decimal), then shifts digits out top first.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_digit_chain import pcf_pkg::*; (
	input  wire                      clk,
	input  chain_ctrl_t              ctrl,
	input  wire  [VALUE_WIDTH-1:0]   load_mag,
	output logic [DIGIT_W-1:0]       top_digit
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [DIGIT_W-1:0]     dig_q    [DIGIT_SLOTS];
	logic [DIGIT_W-1:0]     adj      [DIGIT_SLOTS];
	logic [DIGIT_W-1:0]     stepped  [DIGIT_SLOTS];
	logic                   carry_in [DIGIT_SLOTS];

	always_comb begin
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			if (ctrl.radix == RADIX_DEC && dig_q[i] >= 4'd5) begin
				adj[i] = dig_q[i] + 4'd3;
			end else begin
				adj[i] = dig_q[i];
			end
		end
		carry_in[0] = mag_q[VALUE_WIDTH-1];
		for (int i = 1; i < DIGIT_SLOTS; i++) begin
			carry_in[i] = (ctrl.radix == RADIX_OCT) ? adj[i-1][2] : adj[i-1][3];
		end
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			if (ctrl.radix == RADIX_OCT) begin
				stepped[i] = {1'b0, adj[i][1:0], carry_in[i]};
			end else begin
				stepped[i] = {adj[i][2:0], carry_in[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= load_mag;
			for (int i = 0; i < DIGIT_SLOTS; i++) begin
				dig_q[i] <= '0;
			end
		end else if (ctrl.bit_step) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			for (int i = 0; i < DIGIT_SLOTS; i++) begin
				dig_q[i] <= stepped[i];
			end
		end else if (ctrl.dig_shift) begin
			dig_q[0] <= '0;
			for (int i = 1; i < DIGIT_SLOTS; i++) begin
				dig_q[i] <= dig_q[i-1];
			end
		end
	end

	assign top_digit = dig_q[DIGIT_SLOTS-1];

endmodule

`default_nettype wire

// ----- hdl/pcf_sequencer.sv -----
// ----------------------------------------------------------------------------
// pcf_sequencer - element decode and character sequencing
// Decodes an element, drives the conversion chain, emits prefix characters,
// drops leading zero digits and emits the remaining digits.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_sequencer import pcf_pkg::*; (
	input  wire                     clk,
	input  wire                     arst_n,
	pcf_elem_if.sink                elem,
	input  wire  [DIGIT_W-1:0]      top_digit,
	input  wire                     free,
	output chain_ctrl_t             ctrl,
	output logic [VALUE_WIDTH-1:0]  load_mag,
	output char_push_t              push
);

	state_t              state_q, state_d;
	logic [BIT_CNT_W-1:0] bits_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [1:0]           pre_n_q;
	logic                 num_q;
	logic [CHAR_W-1:0]    pre0_q, pre1_q;
	radix_t               radix_q;
	logic                 upper_q;

	logic                 accept;
	logic                 skip;
	logic                 dec_num;
	logic [1:0]           dec_pre_n;
	logic [CHAR_W-1:0]    dec_pre0, dec_pre1;
	radix_t               dec_radix;
	logic                 dec_upper;
	logic                 dec_full;
	logic [VALUE_WIDTH-1:0] val_w, val_n, val, neg;
	logic                 sign;

	assign accept = elem.valid && elem.ready;
	assign skip   = (top_digit == '0) && (cnt_q != CNT_W'(1));

	// element decode
	always_comb begin
		val_w    = elem.operand[VALUE_WIDTH-1:0];
		val_n    = VALUE_WIDTH'(elem.operand[31:0]);
		dec_full = elem.wide || (elem.func == FN_PTR);
		val      = dec_full ? val_w : val_n;
		sign     = elem.wide ? val_w[VALUE_WIDTH-1] : val_n[31];
		neg      = -val;
		if (!elem.wide) begin
			neg = VALUE_WIDTH'(neg[31:0]);
		end
		dec_num   = 1'b0;
		dec_pre_n = 2'd0;
		dec_pre0  = elem.operand[CHAR_W-1:0];
		dec_pre1  = elem.operand[CHAR_W-1:0];
		dec_radix = RADIX_DEC;
		dec_upper = 1'b0;
		load_mag  = val;
		unique case (elem.func) inside
			FN_LITERAL, FN_CHAR: begin
				dec_pre_n = 2'd1;
			end
			FN_SDEC: begin
				dec_num = 1'b1;
				if (sign) begin
					dec_pre_n = 2'd1;
					dec_pre0  = CH_MINUS;
					load_mag  = neg;
				end
			end
			FN_UDEC: begin
				dec_num = 1'b1;
			end
			FN_HEXL, FN_HEXU: begin
				dec_num   = 1'b1;
				dec_radix = RADIX_HEX;
				dec_upper = (elem.func == FN_HEXU);
			end
			FN_OCT: begin
				dec_num   = 1'b1;
				dec_radix = RADIX_OCT;
			end
			FN_PTR: begin
				dec_num   = 1'b1;
				dec_radix = RADIX_HEX;
				dec_pre_n = 2'd2;
				dec_pre0  = CH_ZERO;
				dec_pre1  = CH_X;
			end
			default: begin
				dec_pre_n = 2'd2;
				dec_pre0  = CH_PCT;
			end
		endcase
		// narrow operands sit left-aligned so that only their 32 bits are stepped
		if (!dec_full) begin
			load_mag = load_mag << (VALUE_WIDTH - 32);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = dec_num ? ST_CONV : ST_PRE;
				end
			end
			ST_CONV: begin
				if (bits_q == BIT_CNT_W'(1)) begin
					state_d = (pre_n_q != 2'd0) ? ST_PRE : ST_SCAN;
				end
			end
			ST_PRE: begin
				if (free && pre_n_q == 2'd1) begin
					state_d = num_q ? ST_SCAN : ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!skip) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (free && cnt_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		elem.ready     = 1'b0;
		ctrl.load      = 1'b0;
		ctrl.bit_step  = 1'b0;
		ctrl.dig_shift = 1'b0;
		ctrl.radix     = radix_q;
		push.valid     = 1'b0;
		push.ch        = pre0_q;
		push.last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				elem.ready = 1'b1;
				ctrl.load  = elem.valid;
			end
			ST_CONV: begin
				ctrl.bit_step = 1'b1;
			end
			ST_PRE: begin
				push.valid = free;
				push.last  = (pre_n_q == 2'd1) && !num_q;
			end
			ST_SCAN: begin
				ctrl.dig_shift = skip;
			end
			ST_EMIT: begin
				push.valid     = free;
				push.ch        = digit_char(top_digit, upper_q);
				push.last      = (cnt_q == CNT_W'(1));
				ctrl.dig_shift = free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bits_q  <= '0;
			cnt_q   <= '0;
			pre_n_q <= '0;
			num_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bits_q  <= dec_full ? BIT_CNT_W'(VALUE_WIDTH) : BIT_CNT_W'(32);
						cnt_q   <= CNT_W'(DIGIT_SLOTS);
						pre_n_q <= dec_pre_n;
						num_q   <= dec_num;
					end
				end
				ST_CONV: begin
					bits_q <= bits_q - BIT_CNT_W'(1);
				end
				ST_PRE: begin
					if (free) begin
						pre_n_q <= pre_n_q - 2'd1;
					end
				end
				ST_SCAN: begin
					if (skip) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (free) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pre0_q  <= dec_pre0;
			pre1_q  <= dec_pre1;
			radix_q <= dec_radix;
			upper_q <= dec_upper;
		end else if (state_q == ST_PRE && free) begin
			pre0_q <= pre1_q;
		end
	end

`ifndef SYNTHESIS
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> free)
		else $error("character pushed into a full output register");
	a_conv_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (bits_q != '0))
		else $error("conversion running with no bits left");
	a_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_EMIT) |-> (cnt_q != '0))
		else $error("digit phase with an empty digit count");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && free && cnt_q == CNT_W'(1)) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after the last digit");
`endif

endmodule

`default_nettype wire

// ----- hdl/pcf_out_stage.sv -----
// ----------------------------------------------------------------------------
// pcf_out_stage - character output register
// Holds one character until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_out_stage import pcf_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  char_push_t  push,
	output logic        free,
	pcf_text_if.source  text
);

	logic              valid_q;
	logic [CHAR_W-1:0] ch_q;
	logic              last_q;

	assign free = !valid_q || text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push.valid) begin
			ch_q   <= push.ch;
			last_q <= push.last;
		end
	end

	assign text.valid = valid_q;
	assign text.ch    = ch_q;
	assign text.last  = last_q;

endmodule

`default_nettype wire

// ----- hdl/printf_conversion_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// printf_conversion_formatter_unit - integer conversion stage of a printf engine
// elem takes one pre-decoded format element per transfer (func, wide, operand);
// text gives its ASCII characters most significant first, last on the final one.
// One element is worked on at a time; elem.ready is high only while idle.
// Literal, char and unknown elements: after acceptance, one character per
// cycle while the receiver takes them (1 or 2 characters).
// Numbers: after acceptance, the bit-serial conversion chain steps through 32
// bits for an int operand or 64 for a long or pointer, then 0..2 prefix
// characters, then up to 21 leading zero digits are dropped, then one digit
// per cycle while the receiver takes them. Scan and emit together pass each
// digit slot once, so without stalls a number's run is the same whatever its
// digit count.
// The output register lets the next element be accepted while the final
// character still waits. When the receiver stalls, character output holds
// in place and resumes without loss. Reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module printf_conversion_formatter_unit import pcf_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	pcf_elem_if.sink   elem,
	pcf_text_if.source text
);

	chain_ctrl_t            ctrl;
	logic [VALUE_WIDTH-1:0] load_mag;
	logic [DIGIT_W-1:0]     top_digit;
	char_push_t             push;
	logic                   free;

	pcf_digit_chain u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.load_mag  (load_mag),
		.top_digit (top_digit)
	);

	pcf_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem      (elem),
		.top_digit (top_digit),
		.free      (free),
		.ctrl      (ctrl),
		.load_mag  (load_mag),
		.push      (push)
	);

	pcf_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.free   (free),
		.text   (text)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench of the printf conversion formatter
// Drives format elements into the element channel and predicts the characters
// that each one must produce. Every character transfer on the text channel is
// checked against the oldest prediction. Both channels idle at random, the
// receiver once holds off long enough to back the block up, and the sender
// once pauses until all predicted text has come out.
// ----------------------------------------------------------------------------
module tb_top;
	import pcf_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNKNOWN = 4'd8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int TAIL_CYCLES    = 150;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_beat_t;

	logic clk;
	logic arst_n;

	pcf_elem_if elem_bus ();
	pcf_text_if text_bus ();

	printf_conversion_formatter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_bus),
		.text   (text_bus)
	);

	text_beat_t pending_text[$];
	int         bad_count;
	int         idle_cycles;
	bit         idling_on;
	bit         hold_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// digits of a magnitude, most significant first
	function automatic string digit_text(input logic [63:0] mag, input radix_t radix,
		input bit upper);
		string       digits;
		string       s;
		logic [63:0] m;
		logic [63:0] base;
		int          d;
		digits = upper ? "0123456789ABCDEF" : "0123456789abcdef";
		case (radix)
			RADIX_HEX: base = 64'd16;
			RADIX_OCT: base = 64'd8;
			default:   base = 64'd10;
		endcase
		s = "";
		m = mag;
		do begin
			d = int'(m % base);
			s = {digits.substr(d, d), s};
			m = m / base;
		end while (m != 64'd0);
		return s;
	endfunction

	function automatic void predict_text(input logic [FUNC_W-1:0] fn, input logic wd,
		input logic [63:0] opnd);
		logic [63:0] val;
		logic [63:0] mag;
		logic [63:0] vmask;
		logic        neg;
		string       txt;
		vmask = wd ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
		val   = opnd & vmask;
		txt   = "";
		case (fn)
			FN_LITERAL, FN_CHAR: begin
				pending_text.push_back(text_beat_t'{ch: opnd[7:0], last: 1'b1});
			end
			FN_SDEC: begin
				neg = wd ? val[63] : val[31];
				mag = neg ? ((~val + 64'd1) & vmask) : val;
				txt = digit_text(mag, RADIX_DEC, 1'b0);
				if (neg) begin
					txt = {"-", txt};
				end
			end
			FN_UDEC: txt = digit_text(val, RADIX_DEC, 1'b0);
			FN_HEXL: txt = digit_text(val, RADIX_HEX, 1'b0);
			FN_HEXU: txt = digit_text(val, RADIX_HEX, 1'b1);
			FN_OCT:  txt = digit_text(val, RADIX_OCT, 1'b0);
			FN_PTR:  txt = {"0x", digit_text(opnd, RADIX_HEX, 1'b0)};
			default: begin
				pending_text.push_back(text_beat_t'{ch: CH_PCT, last: 1'b0});
				pending_text.push_back(text_beat_t'{ch: opnd[7:0], last: 1'b1});
			end
		endcase
		for (int i = 0; i < txt.len(); i++) begin
			pending_text.push_back(text_beat_t'{ch: txt[i], last: (i == txt.len() - 1)});
		end
	endfunction

	task automatic send_element(input logic [FUNC_W-1:0] fn, input logic wd,
		input logic [63:0] opnd);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			elem_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		elem_bus.valid   <= 1'b1;
		elem_bus.func    <= fn;
		elem_bus.wide    <= wd;
		elem_bus.operand <= opnd;
		do @(posedge clk); while (!elem_bus.ready);
		predict_text(fn, wd, opnd);
	endtask

	task automatic wait_drained();
		elem_bus.valid <= 1'b0;
		while (pending_text.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_operand();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 6))
			0: r = 64'($urandom_range(0, 20));
			1: r = {32'($urandom), 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2};
			2: r = {64{1'b1}} - 64'($urandom_range(0, 20));
			3: r = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
			4: r = 64'd1 << $urandom_range(0, 63);
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [FUNC_W-1:0] rand_func();
		if ($urandom_range(0, 9) == 0) begin
			return FUNC_W'($urandom_range(8, 15));
		end
		return FUNC_W'($urandom_range(0, 7));
	endfunction

	task automatic send_random(input int count);
		repeat (count) send_element(rand_func(), 1'($urandom), rand_operand());
	endtask

	task automatic test_directed();
		send_element(FN_LITERAL, 1'b0, 64'h0);
		send_element(FN_LITERAL, 1'b1, {64{1'b1}});
		send_element(FN_CHAR,    1'b0, 64'hA5A5_0000_0000_0041);
		send_element(FN_SDEC,    1'b0, 64'h0000_0000_8000_0000);
		send_element(FN_SDEC,    1'b1, 64'h8000_0000_0000_0000);
		send_element(FN_SDEC,    1'b0, 64'h1234_5678_FFFF_FFFF);
		send_element(FN_SDEC,    1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
		send_element(FN_UDEC,    1'b1, {64{1'b1}});
		send_element(FN_UDEC,    1'b0, 64'hFFFF_FFFF_0000_0000);
		send_element(FN_UDEC,    1'b0, 64'hDEAD_BEEF_FFFF_FFFF);
		send_element(FN_HEXL,    1'b1, 64'h0123_4567_89AB_CDEF);
		send_element(FN_HEXU,    1'b1, 64'hFEDC_BA98_7654_3210);
		send_element(FN_HEXU,    1'b0, 64'hFFFF_FFFF_ABCD_EF01);
		send_element(FN_OCT,     1'b1, {64{1'b1}});
		send_element(FN_OCT,     1'b0, 64'h0);
		send_element(FN_PTR,     1'b0, 64'h0);
		send_element(FN_PTR,     1'b0, {64{1'b1}});
		send_element(FN_UNKNOWN, 1'b1, 64'hFFFF_FFFF_FFFF_FF64);
		for (int f = 9; f < 16; f++) begin
			send_element(FUNC_W'(f), 1'($urandom), {$urandom, $urandom});
		end
	endtask

	task automatic test_random();
		idling_on = 1'b1;
		send_random(300);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		send_random(40);
	endtask

	task automatic test_sender_pause();
		send_random(20);
		wait_drained();
		send_random(20);
	endtask

	task automatic test_steady();
		idling_on = 1'b0;
		send_random(100);
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		text_bus.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				text_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				text_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				text_bus.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_text
		text_beat_t want;
		if (arst_n && text_bus.valid && text_bus.ready) begin
			if (pending_text.size() == 0) begin
				bad_count++;
				if (bad_count <= REPORT_MAX) begin
					$display("unexpected transfer: ch=%h last=%b", text_bus.ch, text_bus.last);
				end
			end else begin
				want = pending_text.pop_front();
				if (text_bus.ch !== want.ch || text_bus.last !== want.last) begin
					bad_count++;
					if (bad_count <= REPORT_MAX) begin
						$display("mismatch: expected ch=%h last=%b, got ch=%h last=%b",
							want.ch, want.last, text_bus.ch, text_bus.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (elem_bus.valid && elem_bus.ready) ||
				(text_bus.valid && text_bus.ready) ||
				(!elem_bus.valid && pending_text.size() == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		bad_count   = 0;
		idling_on   = 1'b0;
		hold_req    = 1'b0;
		arst_n           <= 1'b0;
		elem_bus.valid   <= 1'b0;
		elem_bus.func    <= '0;
		elem_bus.wide    <= 1'b0;
		elem_bus.operand <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_sender_pause();
		test_steady();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		bad_count += pending_text.size();
		if (bad_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
